// ===== rtl/edge_cost_with_turn_penalty_unit_defines.svh =====
// Assertion macros for the edge cost RTL.
// No dependencies; included by ectp_back, which carries the concurrent checks.
`ifndef EDGE_COST_WITH_TURN_PENALTY_UNIT_DEFINES_SVH
`define EDGE_COST_WITH_TURN_PENALTY_UNIT_DEFINES_SVH
`ifndef SYNTH
`define ECTP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ectp check failed");
`define ECTP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ectp check failed");
`else
`define ECTP_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ECTP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ectp_pkg.sv =====
// Shared widths, constants and types for the edge cost unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package ectp_pkg;
    localparam int COORD_BITS  = 24;
    localparam int MAG_BITS    = COORD_BITS + 1;
    localparam int LIM_BITS    = 28;
    localparam int DM          = (MAG_BITS < LIM_BITS) ? MAG_BITS : LIM_BITS;
    localparam int VW          = DM + 1;
    localparam int PRW         = 2 * VW;
    localparam int SQW         = 2 * DM + 2;
    localparam int SR          = DM + 1;
    localparam int RW          = SR + 2;
    localparam int DOTW        = PRW + 2;
    localparam int HW          = 2 * SR;
    localparam int NSW         = DOTW + 1;
    localparam int NW          = HW + 1;
    localparam int QB          = DM + 2;
    localparam int KMAX        = (MAG_BITS > LIM_BITS) ? (MAG_BITS - LIM_BITS) : 0;
    localparam int KB          = $clog2(KMAX + 2);

    localparam int COST_BITS   = 28;
    localparam int WEIGHT_BITS = 10;
    localparam int WEIGHT_FRAC = 8;
    localparam int PENW        = WEIGHT_BITS + QB;
    localparam int PSW         = PENW - WEIGHT_FRAC;
    localparam int SUMA        = (SR > PSW) ? SR : PSW;
    localparam int SUMW        = ((SUMA > COST_BITS) ? SUMA : COST_BITS) + 1;

    localparam logic [COST_BITS-1:0]   COST_MAX     = '1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(205);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int LAT    = SR + QB + 7;
    localparam int RAW    = $clog2(LAT + 2);
    localparam int RDEPTH = 1 << RAW;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [VW-1:0]         t_vec;

    typedef struct packed {
        logic big;
        logic pen_en;
    } t_flags;

    typedef struct packed {
        t_vec   dx;
        t_vec   dy;
        t_vec   dz;
        t_vec   px;
        t_vec   py;
        t_vec   pz;
        t_flags fl;
    } t_item;

    typedef struct packed {
        logic [COST_BITS-1:0] cost;
        logic                 sat;
    } t_res;

    typedef struct packed {
        logic               empty;
        logic [QAW:0]       count;
    } t_qstat;
endpackage
`default_nettype wire

// ===== rtl/ectp_front.sv =====
// Front end: registers an accepted item, forms the two segment vectors,
// flags the special cases and scales a huge parent segment. Uses ectp_pkg.
`default_nettype none
module ectp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic           i_has_parent,
    input  ectp_pkg::t_coord i_par [3],
    input  ectp_pkg::t_coord i_frm [3],
    input  ectp_pkg::t_coord i_tgt [3],
    output logic           o_valid,
    output ectp_pkg::t_item o_item
);
    import ectp_pkg::*;

    logic                      r_valid;
    logic                      r_has_parent;
    t_coord                    r_par [3];
    t_coord                    r_frm [3];
    t_coord                    r_tgt [3];

    logic signed [MAG_BITS-1:0] dd [3];
    logic signed [MAG_BITS-1:0] pd [3];
    logic [MAG_BITS-1:0]        dm [3];
    logic [MAG_BITS-1:0]        pm [3];
    logic [MAG_BITS-1:0]        por;
    logic [KB-1:0]              k;
    t_vec                       dv [3];
    t_vec                       pv [3];
    t_vec                       mg;
    logic                       big;
    logic                       dnz;
    logic                       pnz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_has_parent <= i_has_parent;
            r_par        <= i_par;
            r_frm        <= i_frm;
            r_tgt        <= i_tgt;
        end
    end

    always_comb begin
        big = 1'b0;
        dnz = 1'b0;
        pnz = 1'b0;
        por = '0;
        for (int i = 0; i < 3; i++) begin
            dd[i] = {r_tgt[i][COORD_BITS-1], r_tgt[i]} - {r_frm[i][COORD_BITS-1], r_frm[i]};
            pd[i] = {r_frm[i][COORD_BITS-1], r_frm[i]} - {r_par[i][COORD_BITS-1], r_par[i]};
            dm[i] = dd[i][MAG_BITS-1] ? MAG_BITS'(-dd[i]) : MAG_BITS'(dd[i]);
            pm[i] = pd[i][MAG_BITS-1] ? MAG_BITS'(-pd[i]) : MAG_BITS'(pd[i]);
            big   = big | ((dm[i] >> LIM_BITS) != '0);
            dnz   = dnz | (dm[i] != '0);
            pnz   = pnz | (pm[i] != '0);
            por   = por | pm[i];
        end
        // smallest halving count that brings the parent segment into range
        k = '0;
        for (int s = KMAX; s >= 0; s--) begin
            if (((por >> s) >> LIM_BITS) == '0) begin
                k = KB'(s);
            end
        end
        for (int i = 0; i < 3; i++) begin
            mg    = t_vec'({1'b0, DM'(dm[i])});
            dv[i] = dd[i][MAG_BITS-1] ? -mg : mg;
            mg    = t_vec'({1'b0, DM'(pm[i] >> k)});
            pv[i] = pd[i][MAG_BITS-1] ? -mg : mg;
        end
    end

    assign o_valid          = r_valid;
    assign o_item.dx        = dv[0];
    assign o_item.dy        = dv[1];
    assign o_item.dz        = dv[2];
    assign o_item.px        = pv[0];
    assign o_item.py        = pv[1];
    assign o_item.pz        = pv[2];
    assign o_item.fl.big    = big;
    assign o_item.fl.pen_en = r_has_parent & dnz & pnz;
endmodule
`default_nettype wire

// ===== rtl/ectp_queue.sv =====
// Short item queue between front and back end.
// Uses ectp_pkg for the item type and depth.
`default_nettype none
module ectp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ectp_pkg::t_item i_item,
    input  logic            i_pop,
    output ectp_pkg::t_item o_head,
    output ectp_pkg::t_qstat o_stat
);
    import ectp_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;
endmodule
`default_nettype wire

// ===== rtl/ectp_back.sv =====
// Back end: squares, dot product, two square roots, cosine clamp, divider,
// weighting and saturation, then a result buffer. Uses ectp_pkg and the defines.
`default_nettype none
`include "edge_cost_with_turn_penalty_unit_defines.svh"
module ectp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_issue,
    input  ectp_pkg::t_item                 i_item,
    input  logic [ectp_pkg::WEIGHT_BITS-1:0] i_weight,
    input  logic                            i_pop,
    output logic                            o_can_issue,
    output logic                            o_empty,
    output ectp_pkg::t_res                  o_res
);
    import ectp_pkg::*;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [SR-1:0] root;
    } t_sqs;

    typedef struct packed {
        logic [SR-1:0] rem;
        logic [QB-1:0] q;
    } t_dvs;

    function automatic t_sqs sq_step(input t_sqs s, input logic [1:0] b);
        t_sqs          o;
        logic [RW-1:0] cand;
        logic [RW-1:0] trial;
        cand  = {s.rem[RW-3:0], b};
        trial = {s.root, 2'b01};
        if (cand >= trial) begin
            o.rem  = cand - trial;
            o.root = {s.root[SR-2:0], 1'b1};
        end else begin
            o.rem  = cand;
            o.root = {s.root[SR-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_dvs dv_step(input t_dvs s, input logic b, input logic [SR-1:0] dvs);
        t_dvs        o;
        logic [SR:0] cand;
        cand = {s.rem, b};
        if (cand >= {1'b0, dvs}) begin
            o.rem = SR'(cand - {1'b0, dvs});
            o.q   = {s.q[QB-2:0], 1'b1};
        end else begin
            o.rem = SR'(cand);
            o.q   = {s.q[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    // issue and products
    logic                    r_s0_v;
    t_item                   r_s0_it;
    logic                    r_s1_v;
    t_flags                  r_s1_fl;
    logic signed [PRW-1:0]   r_s1_sqd [3];
    logic signed [PRW-1:0]   r_s1_sqp [3];
    logic signed [PRW-1:0]   r_s1_dp  [3];
    logic                    r_s2_v;
    t_flags                  r_s2_fl;
    logic [SQW-1:0]          r_s2_sumd;
    logic [SQW-1:0]          r_s2_sump;
    logic signed [DOTW-1:0]  r_s2_dot;
    t_vec                    dvec [3];
    t_vec                    pvec [3];

    // square root stages, one result bit each
    logic                    r_sq_v   [SR];
    t_flags                  r_sq_fl  [SR];
    logic signed [DOTW-1:0]  r_sq_dot [SR];
    t_sqs                    r_sq_d   [SR];
    t_sqs                    r_sq_p   [SR];
    logic [SQW-1:0]          r_sq_vd  [SR];
    logic [SQW-1:0]          r_sq_vp  [SR];
    t_sqs                    a_sq_d   [SR];
    t_sqs                    a_sq_p   [SR];
    logic [SQW-1:0]          a_sq_vd  [SR];
    logic [SQW-1:0]          a_sq_vp  [SR];

    logic                    r_h_v;
    t_flags                  r_h_fl;
    logic [HW-1:0]           r_h_hi;
    logic [SR-1:0]           r_h_len;
    logic [SR-1:0]           r_h_plen;
    logic signed [DOTW-1:0]  r_h_dot;

    logic                    r_n_v;
    t_flags                  r_n_fl;
    logic [NW-1:0]           r_n_num;
    logic [SR-1:0]           r_n_len;
    logic [SR-1:0]           r_n_plen;
    logic signed [NSW-1:0]   n_diff;
    logic [NW-1:0]           n_twice;
    logic [NW-1:0]           n_num;

    // divider stages, one quotient bit each
    logic                    r_dv_v    [QB];
    t_flags                  r_dv_fl   [QB];
    t_dvs                    r_dv_s    [QB];
    logic [QB-1:0]           r_dv_nl   [QB];
    logic [SR-1:0]           r_dv_len  [QB];
    logic [SR-1:0]           r_dv_plen [QB];
    t_dvs                    a_dv_s    [QB];
    logic [QB-1:0]           a_dv_nl   [QB];
    logic [SR-1:0]           a_dv_plen [QB];

    logic                    r_p_v;
    t_flags                  r_p_fl;
    logic [PSW-1:0]          r_p_pen;
    logic [SR-1:0]           r_p_len;
    logic [PENW-1:0]         n_prod;
    logic [SUMW-1:0]         n_total;
    t_res                    n_res;

    // result buffer and credit count
    t_res                    r_mem [RDEPTH];
    logic [RAW:0]            r_wp;
    logic [RAW:0]            r_rp;
    logic [RAW:0]            r_oc;
    logic                    r_ov;
    t_res                    r_out;
    logic [RAW:0]            mem_cnt;
    logic                    load;

    assign dvec = '{r_s0_it.dx, r_s0_it.dy, r_s0_it.dz};
    assign pvec = '{r_s0_it.px, r_s0_it.py, r_s0_it.pz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_sq_v <= '{default: 1'b0};
            r_h_v  <= 1'b0;
            r_n_v  <= 1'b0;
            r_dv_v <= '{default: 1'b0};
            r_p_v  <= 1'b0;
        end else begin
            r_s0_v    <= i_issue;
            r_s1_v    <= r_s0_v;
            r_s2_v    <= r_s1_v;
            r_sq_v[0] <= r_s2_v;
            for (int k = 1; k < SR; k++) begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
            r_h_v     <= r_sq_v[SR-1];
            r_n_v     <= r_h_v;
            r_dv_v[0] <= r_n_v;
            for (int j = 1; j < QB; j++) begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
            r_p_v     <= r_dv_v[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_s0_it <= i_item;
        end
        r_s1_fl <= r_s0_it.fl;
        for (int i = 0; i < 3; i++) begin
            r_s1_sqd[i] <= dvec[i] * dvec[i];
            r_s1_sqp[i] <= pvec[i] * pvec[i];
            r_s1_dp[i]  <= pvec[i] * dvec[i];
        end
        r_s2_fl   <= r_s1_fl;
        r_s2_sumd <= SQW'(r_s1_sqd[0]) + SQW'(r_s1_sqd[1]) + SQW'(r_s1_sqd[2]);
        r_s2_sump <= SQW'(r_s1_sqp[0]) + SQW'(r_s1_sqp[1]) + SQW'(r_s1_sqp[2]);
        r_s2_dot  <= DOTW'(r_s1_dp[0]) + DOTW'(r_s1_dp[1]) + DOTW'(r_s1_dp[2]);
    end

    always_comb begin
        for (int k = 0; k < SR; k++) begin
            if (k == 0) begin
                a_sq_d[k]  = '0;
                a_sq_p[k]  = '0;
                a_sq_vd[k] = r_s2_sumd;
                a_sq_vp[k] = r_s2_sump;
            end else begin
                a_sq_d[k]  = r_sq_d[k-1];
                a_sq_p[k]  = r_sq_p[k-1];
                a_sq_vd[k] = r_sq_vd[k-1];
                a_sq_vp[k] = r_sq_vp[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_fl[0]  <= r_s2_fl;
        r_sq_dot[0] <= r_s2_dot;
        for (int k = 1; k < SR; k++) begin
            r_sq_fl[k]  <= r_sq_fl[k-1];
            r_sq_dot[k] <= r_sq_dot[k-1];
        end
        for (int k = 0; k < SR; k++) begin
            r_sq_d[k]  <= sq_step(a_sq_d[k], a_sq_vd[k][SQW-1:SQW-2]);
            r_sq_p[k]  <= sq_step(a_sq_p[k], a_sq_vp[k][SQW-1:SQW-2]);
            r_sq_vd[k] <= a_sq_vd[k] << 2;
            r_sq_vp[k] <= a_sq_vp[k] << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_fl   <= r_sq_fl[SR-1];
        r_h_dot  <= r_sq_dot[SR-1];
        r_h_len  <= r_sq_d[SR-1].root;
        r_h_plen <= r_sq_p[SR-1].root;
        r_h_hi   <= HW'(r_sq_d[SR-1].root) * HW'(r_sq_p[SR-1].root);
    end

    // cosine clamp: numerator kept within [0, 2*|p|*|d|]
    always_comb begin
        n_diff  = $signed({{(NSW-HW){1'b0}}, r_h_hi}) - NSW'(r_h_dot);
        n_twice = {r_h_hi, 1'b0};
        if (n_diff < 0) begin
            n_num = '0;
        end else if (n_diff > $signed({{(NSW-NW){1'b0}}, n_twice})) begin
            n_num = n_twice;
        end else begin
            n_num = NW'(n_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        r_n_fl   <= r_h_fl;
        r_n_num  <= n_num;
        r_n_len  <= r_h_len;
        r_n_plen <= r_h_plen;
    end

    always_comb begin
        for (int j = 0; j < QB; j++) begin
            if (j == 0) begin
                a_dv_s[j].rem = r_n_num[NW-1:QB];
                a_dv_s[j].q   = '0;
                a_dv_nl[j]    = r_n_num[QB-1:0];
                a_dv_plen[j]  = r_n_plen;
            end else begin
                a_dv_s[j]     = r_dv_s[j-1];
                a_dv_nl[j]    = r_dv_nl[j-1];
                a_dv_plen[j]  = r_dv_plen[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_fl[0]  <= r_n_fl;
        r_dv_len[0] <= r_n_len;
        for (int j = 1; j < QB; j++) begin
            r_dv_fl[j]  <= r_dv_fl[j-1];
            r_dv_len[j] <= r_dv_len[j-1];
        end
        for (int j = 0; j < QB; j++) begin
            r_dv_s[j]    <= dv_step(a_dv_s[j], a_dv_nl[j][QB-1], a_dv_plen[j]);
            r_dv_nl[j]   <= a_dv_nl[j] << 1;
            r_dv_plen[j] <= a_dv_plen[j];
        end
    end

    assign n_prod = PENW'(i_weight) * PENW'(r_dv_s[QB-1].q);

    always_ff @(posedge i_clk) begin
        r_p_fl  <= r_dv_fl[QB-1];
        r_p_len <= r_dv_len[QB-1];
        r_p_pen <= n_prod[PENW-1:WEIGHT_FRAC];
    end

    always_comb begin
        n_total = r_p_fl.pen_en ? (SUMW'(r_p_len) + SUMW'(r_p_pen)) : SUMW'(r_p_len);
        n_res.sat  = r_p_fl.big || (n_total > SUMW'(COST_MAX));
        n_res.cost = n_res.sat ? COST_MAX : COST_BITS'(n_total);
    end

    assign mem_cnt     = r_wp - r_rp;
    assign load        = (mem_cnt != '0) && (!r_ov || i_pop);
    assign o_can_issue = (r_oc < (RAW+1)'(RDEPTH));
    assign o_empty     = !r_ov;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (r_p_v) begin
            r_mem[r_wp[RAW-1:0]] <= n_res;
        end
        if (load) begin
            r_out <= r_mem[r_rp[RAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_oc <= '0;
            r_ov <= 1'b0;
        end else begin
            if (r_p_v) begin
                r_wp <= r_wp + 1'b1;
            end
            if (load) begin
                r_rp <= r_rp + 1'b1;
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            r_oc <= r_oc + (RAW+1)'(i_issue) - (RAW+1)'(i_pop);
        end
    end

    `ECTP_ASSERT_ALWAYS(a_credit_bound, i_clk, i_rst_n, r_oc <= (RAW+1)'(RDEPTH))
    `ECTP_ASSERT_ALWAYS(a_buffer_covered, i_clk, i_rst_n, (mem_cnt + (RAW+1)'(r_ov)) <= r_oc)
    `ECTP_ASSERT_IMPLY(a_sat_is_max, i_clk, i_rst_n, r_ov && r_out.sat, r_out.cost == COST_MAX)
endmodule
`default_nettype wire

// ===== rtl/edge_cost_with_turn_penalty_unit.sv =====
// Edge cost with turn penalty: Euclidean length plus weighted turn penalty.
// Data path: front register, item queue, two square-root pipelines (26 stages)
// and the restoring divider (27 stages); a 64-entry result buffer holds work in flight.
// Throughput: one transaction per cycle while full is low and buffer credit remains.
// Reset (synchronous, active low) empties all queues and sets the weight to 205.
`default_nettype none
module edge_cost_with_turn_penalty_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    output logic                             empty,
    input  logic                             pop,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ectp_pkg::WEIGHT_BITS-1:0] i_cfg_data,
    input  logic                             i_has_parent,
    input  logic signed [ectp_pkg::COORD_BITS-1:0] i_parent_x,
    input  logic signed [ectp_pkg::COORD_BITS-1:0] i_parent_y,
    input  logic signed [ectp_pkg::COORD_BITS-1:0] i_parent_z,
    input  logic signed [ectp_pkg::COORD_BITS-1:0] i_from_x,
    input  logic signed [ectp_pkg::COORD_BITS-1:0] i_from_y,
    input  logic signed [ectp_pkg::COORD_BITS-1:0] i_from_z,
    input  logic signed [ectp_pkg::COORD_BITS-1:0] i_target_x,
    input  logic signed [ectp_pkg::COORD_BITS-1:0] i_target_y,
    input  logic signed [ectp_pkg::COORD_BITS-1:0] i_target_z,
    output logic [ectp_pkg::COST_BITS-1:0]   o_cost,
    output logic                             o_saturated
);
    import ectp_pkg::*;

    logic [WEIGHT_BITS-1:0] r_weight;
    logic                   take;
    logic                   f_valid;
    t_item                  f_item;
    t_item                  q_head;
    t_qstat                 q_stat;
    logic                   issue;
    logic                   can_issue;
    logic                   b_empty;
    t_res                   b_res;
    t_coord                 par [3];
    t_coord                 frm [3];
    t_coord                 tgt [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_valid) begin
            r_weight <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    // the front register's item is already owed a queue slot
    assign full  = ((q_stat.count + (QAW+1)'(f_valid)) >= (QAW+1)'(QDEPTH));
    assign take  = push && !full;
    assign issue = !q_stat.empty && can_issue;
    assign par   = '{i_parent_x, i_parent_y, i_parent_z};
    assign frm   = '{i_from_x, i_from_y, i_from_z};
    assign tgt   = '{i_target_x, i_target_y, i_target_z};

    ectp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_has_parent (i_has_parent),
        .i_par        (par),
        .i_frm        (frm),
        .i_tgt        (tgt),
        .o_valid      (f_valid),
        .o_item       (f_item)
    );

    ectp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .i_pop   (issue),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    ectp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_item      (q_head),
        .i_weight    (r_weight),
        .i_pop       (pop && !b_empty),
        .o_can_issue (can_issue),
        .o_empty     (b_empty),
        .o_res       (b_res)
    );

    assign empty       = b_empty;
    assign o_cost      = b_res.cost;
    assign o_saturated = b_res.sat;
endmodule
`default_nettype wire

// ===== tb/sv/edge_cost_with_turn_penalty_unit_tb.sv =====
// Self-checking testbench for edge_cost_with_turn_penalty_unit: random and directed
// point triples, checked against an in-bench cost predictor. Depends on ectp_pkg and the RTL.
`default_nettype none
module edge_cost_with_turn_penalty_unit_tb;
    import ectp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 80;     // beyond the push-to-result latency
    localparam int PHASE_ITEMS = 325;

    typedef struct {
        logic                       has_parent;
        logic [2:0][COORD_BITS-1:0] par;
        logic [2:0][COORD_BITS-1:0] frm;
        logic [2:0][COORD_BITS-1:0] tgt;
    } t_edge_item;

    typedef struct {
        logic [COST_BITS-1:0] cost;
        logic                 sat;
    } t_cost;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [WEIGHT_BITS-1:0] i_cfg_data = '0;
    logic i_has_parent = 1'b0;
    logic [2:0][COORD_BITS-1:0] par_q = '0, frm_q = '0, tgt_q = '0;
    logic [COST_BITS-1:0] o_cost;
    logic o_saturated;

    t_edge_item pending_edges[$];
    t_cost      expected_costs[$];
    logic [WEIGHT_BITS-1:0] weight_model = WEIGHT_RESET;
    int  n_sent = 0, n_checked = 0, n_fail = 0, n_sat = 0;
    int  cycles = 0, tx_gap = 0, rx_gap = 0;
    bit  steady = 0;     // phases with no idling on either side
    bit  rx_hold = 0;

    edge_cost_with_turn_penalty_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .empty(empty), .pop(pop),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_has_parent(i_has_parent),
        .i_parent_x(par_q[0]), .i_parent_y(par_q[1]), .i_parent_z(par_q[2]),
        .i_from_x(frm_q[0]), .i_from_y(frm_q[1]), .i_from_z(frm_q[2]),
        .i_target_x(tgt_q[0]), .i_target_y(tgt_q[1]), .i_target_z(tgt_q[2]),
        .o_cost(o_cost), .o_saturated(o_saturated)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_cost predict_cost(t_edge_item it, logic [WEIGHT_BITS-1:0] w);
        longint d[3], p[3];
        longint unsigned sd, sp, len, plen, t, pen, total;
        longint dot, hi, num;
        longint lim;
        bit big, p_big;
        t_cost r;
        lim = longint'(1) << COST_BITS;
        big = 0;
        sd = 0;
        sp = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'($signed(it.tgt[i])) - longint'($signed(it.frm[i]));
            p[i] = longint'($signed(it.frm[i])) - longint'($signed(it.par[i]));
            if (abs64(d[i]) >= lim) big = 1;
        end
        if (big) begin
            r.cost = COST_MAX;
            r.sat = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) sd += longint'(d[i] * d[i]);
        len = int_sqrt(sd);
        total = len;
        if (it.has_parent && sd != 0 && (p[0] != 0 || p[1] != 0 || p[2] != 0)) begin
            p_big = 1;
            while (p_big) begin
                p_big = 0;
                for (int i = 0; i < 3; i++) if (abs64(p[i]) >= lim) p_big = 1;
                if (p_big)
                    for (int i = 0; i < 3; i++) p[i] = (p[i] < 0) ? -(abs64(p[i]) >> 1) : (p[i] >> 1);
            end
            for (int i = 0; i < 3; i++) begin
                sp += longint'(p[i] * p[i]);
                dot += p[i] * d[i];
            end
            plen = int_sqrt(sp);
            hi = longint'(plen * len);
            num = hi - dot;
            if (num < 0) num = 0;
            if (num > 2 * hi) num = 2 * hi;
            t = longint'(num) / plen;
            pen = (longint'(w) * t) >> WEIGHT_FRAC;
            total = len + pen;
        end
        if (total > longint'(COST_MAX)) begin
            r.cost = COST_MAX;
            r.sat = 1'b1;
        end else begin
            r.cost = total[COST_BITS-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // mostly back-to-back, some short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [COORD_BITS-1:0] near(logic [COORD_BITS-1:0] base, int span);
        int off;
        off = $signed($urandom_range(0, 2 * span)) - span;
        return COORD_BITS'(int'($signed(base)) + off);
    endfunction

    function automatic t_edge_item random_edge();
        t_edge_item it;
        int kind, span, a, b;
        logic [2:0][COORD_BITS-1:0] v;
        kind = $urandom_range(0, 9);
        it.has_parent = ($urandom_range(0, 7) != 0);
        for (int i = 0; i < 3; i++) begin
            it.par[i] = COORD_BITS'($urandom());
            it.frm[i] = COORD_BITS'($urandom());
            it.tgt[i] = COORD_BITS'($urandom());
        end
        if (kind >= 3 && kind <= 6) begin
            // clustered points: short segments, any angle
            span = 1 << $urandom_range(0, 18);
            for (int i = 0; i < 3; i++) begin
                it.frm[i] = COORD_BITS'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
                it.par[i] = near(it.frm[i], span);
                it.tgt[i] = near(it.frm[i], span);
            end
        end else if (kind == 7 || kind == 8) begin
            // collinear: straight on or full reversal
            a = $urandom_range(1, 8);
            b = $urandom_range(1, 8) * (($urandom_range(0, 1) != 0) ? 1 : -1);
            for (int i = 0; i < 3; i++) begin
                v[i] = COORD_BITS'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
                it.frm[i] = COORD_BITS'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
                it.par[i] = COORD_BITS'(int'($signed(it.frm[i])) - a * int'($signed(v[i])));
                it.tgt[i] = COORD_BITS'(int'($signed(it.frm[i])) + b * int'($signed(v[i])));
            end
        end else if (kind == 9) begin
            if ($urandom_range(0, 1) != 0) it.tgt = it.frm;
            else it.par = it.frm;
        end
        return it;
    endfunction

    function automatic t_edge_item make_edge(bit hp, int px, int py, int pz,
                                             int fx, int fy, int fz, int tx, int ty, int tz);
        t_edge_item it;
        it.has_parent = hp;
        it.par = {COORD_BITS'(pz), COORD_BITS'(py), COORD_BITS'(px)};
        it.frm = {COORD_BITS'(fz), COORD_BITS'(fy), COORD_BITS'(fx)};
        it.tgt = {COORD_BITS'(tz), COORD_BITS'(ty), COORD_BITS'(tx)};
        return it;
    endfunction

    task automatic queue_edge(t_edge_item it);
        pending_edges.insert(pending_edges.size(), it);
    endtask

    // driver: one transaction per edge when push is high and full is low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (push) begin
                expected_costs.insert(expected_costs.size(),
                    predict_cost(t_edge_item'{i_has_parent, par_q, frm_q, tgt_q},
                                 weight_model));
                n_sent++;
            end
            if (tx_gap > 0) begin
                tx_gap--;
                push <= 1'b0;
            end else if (pending_edges.size() != 0) begin
                t_edge_item it;
                it = pending_edges.pop_front();
                i_has_parent <= it.has_parent;
                par_q <= it.par;
                frm_q <= it.frm;
                tgt_q <= it.tgt;
                push <= 1'b1;
                tx_gap = pick_gap();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor: checks each popped cost against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_costs.size() == 0) begin
                $error("unexpected result: cost %0d saturated %0d", o_cost, o_saturated);
                n_fail++;
            end else begin
                t_cost e;
                e = expected_costs.pop_front();
                if (o_cost !== e.cost) begin
                    $error("cost: expected %0d, got %0d", e.cost, o_cost);
                    n_fail++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated: expected %0d, got %0d", e.sat, o_saturated);
                    n_fail++;
                end
                if (e.sat) n_sat++;
            end
            n_checked++;
            rx_gap = pick_gap();
        end
        if (!i_rst_n || rx_hold) begin
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // long receiver stall once traffic is flowing, so the buffer fills and full rises
    initial begin
        wait (n_sent >= 400);
        @(posedge i_clk);
        rx_hold = 1;
        repeat (400) @(posedge i_clk);
        rx_hold = 0;
    end

    task automatic drain();
        while (pending_edges.size() != 0 || expected_costs.size() != 0 || push)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_weight(logic [WEIGHT_BITS-1:0] w);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        weight_model = w;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [WEIGHT_BITS-1:0] weights[6];
        int M, N;
        M = (1 << (COORD_BITS - 1)) - 1;
        N = -(1 << (COORD_BITS - 1));
        weights = '{10'd205, 10'd0, 10'd1023, 10'd1, 10'd256, 10'd205};
        weights[5] = WEIGHT_BITS'($urandom_range(0, 1023));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed edges at the reset weight
        queue_edge(make_edge(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_edge(make_edge(1, 0, 0, 0, 4096, 0, 0, 4096, 0, 0));
        queue_edge(make_edge(0, N, N, N, N, N, N, M, M, M));
        queue_edge(make_edge(1, M, M, M, N, N, N, M, M, M));
        queue_edge(make_edge(1, N, N, N, M, M, M, N, N, N));
        queue_edge(make_edge(1, M, N, M, N, M, N, M, N, M));
        queue_edge(make_edge(1, 5, 5, 5, 5, 5, 5, 900, -3, 7));
        queue_edge(make_edge(0, 1, 2, 3, 0, 0, 0, 4096, 4096, 4096));
        queue_edge(make_edge(1, -4096, 0, 0, 0, 0, 0, 4096, 0, 0));
        queue_edge(make_edge(1, 4096, 0, 0, 0, 0, 0, 4096, 0, 0));
        queue_edge(make_edge(1, 0, -4096, 0, 0, 0, 0, 4096, 0, 0));
        queue_edge(make_edge(1, 0, 0, 0, 1, 0, 0, 2, 0, 0));
        queue_edge(make_edge(1, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        queue_edge(make_edge(1, 0, 0, 0, 0, 0, 1, 0, 1, 1));
        queue_edge(make_edge(1, N, 0, 0, M, 0, 0, N, 0, 0));
        queue_edge(make_edge(1, 0, 0, N, 0, 0, M, 0, M, N));
        queue_edge(make_edge(1, -1, -1, -1, 0, 0, 0, -1, -1, -1));
        queue_edge(make_edge(1, 3, -7, 11, -2, 9, 4, 8, -6, 1));

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) write_weight(weights[ph]);
            steady = (ph == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) queue_edge(random_edge());
            if (ph == 3) begin
                // extremes again at the smallest non-zero weight
                queue_edge(make_edge(1, N, N, N, M, M, M, N, N, N));
                queue_edge(make_edge(1, M, N, M, N, M, N, M, N, M));
            end
            drain();
        end
        write_weight(1023);
        queue_edge(make_edge(1, N, N, N, M, M, M, N, N, N));
        queue_edge(make_edge(1, M, M, M, N, N, N, M, M, M));
        drain();

        $display("%0d edges sent over 7 weight settings (0, 1, 1023 among them), %0d results checked, %0d saturated",
                 n_sent, n_checked, n_sat);
        $display("including clustered, collinear, reversed and zero-length segments and a long output stall");
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/ectp_pkg.sv
rtl/ectp_front.sv
rtl/ectp_queue.sv
rtl/ectp_back.sv
rtl/edge_cost_with_turn_penalty_unit.sv
tb/sv/edge_cost_with_turn_penalty_unit_tb.sv
